// File: design/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by uer_distance, ultrasonic_echo_ranger, ranger_checker and the testbench
package uer_pkg;

   localparam int ECHO_COUNT_BITS_DEF = 16;

   localparam int INTERVAL_BITS = 20;
   localparam int TRIG_BITS     = 8;
   localparam int PULSE_BITS    = 9;
   localparam int DIST_BITS     = 11;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;

   // 0.017 cm per tick in unsigned q0.16
   localparam int DIST_SCALE      = 1114;
   localparam int DIST_SCALE_BITS = 11;
   localparam int DIST_FRAC_BITS  = 16;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RST = 20'd60000;
   localparam logic [TRIG_BITS-1:0]     TRIG_HIGH_RST    = 8'd10;
   localparam logic [TRIG_BITS-1:0]     SETTLE_LOW_RST   = 8'd5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIG_HIGH    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE_LOW   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_IDLE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BUSY  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_MEAS  = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_AWAIT = 2'd1,
      PH_MEAS  = 2'd2,
      PH_PULSE = 2'd3
   } phase_type;

endpackage

// File: design/uer_distance.sv
// echo width to distance: count * 1114 >> 16, saturated to the 11 bit range
// depends on uer_pkg
module uer_distance #(
   parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
   input  logic [ECHO_COUNT_BITS-1:0] echo_count,
   output logic [uer_pkg::DIST_BITS-1:0] distance
);
   import uer_pkg::*;

   localparam int PW = ECHO_COUNT_BITS + DIST_SCALE_BITS;
   localparam int QW = PW - DIST_FRAC_BITS;
   localparam int SW = (QW > DIST_BITS) ? QW : DIST_BITS;

   logic [PW-1:0] product;
   logic [SW-1:0] quotient;

   assign product  = PW'(echo_count) * PW'(DIST_SCALE);
   assign quotient = SW'(product >> DIST_FRAC_BITS);
   assign distance = (quotient > SW'(DIST_MAX)) ? DIST_MAX : quotient[DIST_BITS-1:0];

endmodule

// File: design/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger, top level. One req word is one microsecond tick of the echo pin
// plus a start flag; every accepted word yields exactly one rsp word in the next cycle,
// and a new word is taken on every cycle. The only stall is a full result register with
// rsp_tready low. A start while idle, once min_interval_ticks have passed since the last
// measurement, drives the trigger low for settle_low_ticks, high for trigger_high_ticks,
// then low; the echo high time is counted (saturating) and on its fall the distance
// (count * 1114) >> 16 cm is reported with measure_done set.
// depends on uer_pkg and uer_distance
module ultrasonic_echo_ranger #(
   parameter int ECHO_COUNT_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [uer_pkg::REQ_DATA_BITS-1:0] req_tdata, // echo_level, start_request
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // trigger_level, phase_status[1:0], distance_cm[10:0], measure_done
   output logic [uer_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [uer_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import uer_pkg::*;

   localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;
   localparam logic [INTERVAL_BITS-1:0]   INTERVAL_MAX = '1;

   // configuration
   logic [INTERVAL_BITS-1:0] min_interval_ff;
   logic [TRIG_BITS-1:0]     trig_high_ff;
   logic [TRIG_BITS-1:0]     settle_low_ff;

   // measurement state
   phase_type                phase_ff, phase_in, phase_eff;
   logic [PULSE_BITS-1:0]    pulse_ff, pulse_in, pulse_eff;
   logic [ECHO_COUNT_BITS-1:0] echo_cnt_ff, echo_cnt_in;
   logic [INTERVAL_BITS-1:0] since_ff, since_in;
   logic [DIST_BITS-1:0]     dist_ff, dist_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   logic                     accept;
   logic                     echo_level, start_request;
   logic                     interval_ok;
   logic [PULSE_BITS-1:0]    pulse_total;
   logic [DIST_BITS-1:0]     dist_calc;
   logic                     trig_out;
   logic                     done_out;
   logic [STATUS_BITS-1:0]   status_out;

   assign echo_level    = req_tdata[0];
   assign start_request = req_tdata[1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign interval_ok = since_ff >= min_interval_ff;
   assign pulse_total = PULSE_BITS'(settle_low_ff) + PULSE_BITS'(trig_high_ff);

   uer_distance #(
      .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
   ) u_distance (
      .echo_count(echo_cnt_ff),
      .distance  (dist_calc)
   );

   // a start is folded into this tick as pulse tick zero
   always_comb begin
      phase_eff = phase_ff;
      pulse_eff = pulse_ff;
      if (phase_ff == PH_IDLE && start_request && interval_ok) begin
         phase_eff = PH_PULSE;
         pulse_eff = '0;
      end
   end

   always_comb begin
      pulse_in = pulse_eff;
      if (phase_eff == PH_PULSE && pulse_eff < pulse_total) begin
         pulse_in = pulse_eff + 1'b1;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_eff;
      case (phase_eff)
         PH_PULSE: begin
            if (pulse_in >= pulse_total) begin
               phase_in = PH_AWAIT;
            end
         end
         PH_AWAIT: begin
            if (echo_level) begin
               phase_in = PH_MEAS;
            end
         end
         PH_MEAS: begin
            if (!echo_level) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = phase_eff;
      endcase
   end

   // outputs and datapath
   always_comb begin
      trig_out    = 1'b0;
      done_out    = 1'b0;
      echo_cnt_in = echo_cnt_ff;
      dist_in     = dist_ff;
      since_in    = (since_ff == INTERVAL_MAX) ? since_ff : since_ff + 1'b1;
      case (phase_eff)
         PH_PULSE: begin
            trig_out = (pulse_eff >= PULSE_BITS'(settle_low_ff)) && (pulse_eff < pulse_total);
         end
         PH_AWAIT: begin
            if (echo_level) begin
               echo_cnt_in = ECHO_COUNT_BITS'(1);
            end
         end
         PH_MEAS: begin
            if (echo_level) begin
               if (echo_cnt_ff != ECHO_MAX) begin
                  echo_cnt_in = echo_cnt_ff + 1'b1;
               end
            end else begin
               dist_in  = dist_calc;
               done_out = 1'b1;
               since_in = '0;
            end
         end
         default: trig_out = 1'b0;
      endcase
      case (phase_in)
         PH_MEAS: status_out = STATUS_MEAS;
         PH_IDLE: status_out = STATUS_IDLE;
         default: status_out = STATUS_BUSY;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= MIN_INTERVAL_RST;
         trig_high_ff    <= TRIG_HIGH_RST;
         settle_low_ff   <= SETTLE_LOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_INTERVAL: min_interval_ff <= csr_wdata[INTERVAL_BITS-1:0];
            CSR_TRIG_HIGH:    trig_high_ff    <= csr_wdata[TRIG_BITS-1:0];
            CSR_SETTLE_LOW:   settle_low_ff   <= csr_wdata[TRIG_BITS-1:0];
            default:          min_interval_ff <= min_interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pulse_ff     <= '0;
         echo_cnt_ff  <= '0;
         since_ff     <= INTERVAL_MAX;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            pulse_ff    <= pulse_in;
            echo_cnt_ff <= echo_cnt_in;
            since_ff    <= since_in;
            dist_ff     <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= RSP_DATA_BITS'({done_out, dist_in, status_out, trig_out});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a finished measurement leaves the block idle with the trigger low
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[2:1] == STATUS_IDLE && !rsp_tdata[0])
      else $error("done word not idle");

   // trigger is only driven high during the pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2:1] == STATUS_BUSY)
      else $error("trigger high outside pulse");

   // measuring always holds at least one echo tick
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MEAS |-> echo_cnt_ff != '0)
      else $error("empty echo count while measuring");

   // end of a measurement restarts the interval count
   assert property (@(posedge clock) disable iff (reset)
      accept && done_out |=> since_ff == '0 && phase_ff == PH_IDLE)
      else $error("interval not restarted");

endmodule

// File: tb/ranger_checker.sv
// result checker for the ultrasonic echo ranger: tracks csr writes, predicts every rsp word
// from the accepted req words and compares field by field; depends on uer_pkg only
module ranger_checker #(
   parameter int ECHO_BITS = uer_pkg::ECHO_COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [uer_pkg::REQ_DATA_BITS-1:0] req_tdata, // echo_level, start_request
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   // trigger_level, phase_status[1:0], distance_cm[10:0], measure_done
   input  logic [uer_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [uer_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int mismatches,
   output int distances_seen,
   output int backlog
);
   import uer_pkg::*;

   typedef struct {
      logic                   trig;
      logic [STATUS_BITS-1:0] status;
      logic [DIST_BITS-1:0]   range_cm;
      logic                   done;
   } reading_type;

   reading_type pending_readings[$];

   logic [INTERVAL_BITS-1:0] min_gap;
   logic [TRIG_BITS-1:0]     high_len;
   logic [TRIG_BITS-1:0]     settle_len;

   phase_type                ph;
   logic [PULSE_BITS-1:0]    pulse_n;
   logic [ECHO_BITS-1:0]     echo_n;
   logic [INTERVAL_BITS-1:0] since_n;
   logic [DIST_BITS-1:0]     dist_q;

   // one microsecond tick of the ranger
   task automatic step_ranger(input logic echo, input logic start, output reading_type r);
      logic ready_again;
      logic [PULSE_BITS:0] span;
      logic [ECHO_BITS+DIST_SCALE_BITS-1:0] product;
      r.trig = 1'b0;
      r.done = 1'b0;
      ready_again = (since_n >= min_gap);
      if (since_n != '1) since_n = since_n + 1'b1;
      if (ph == PH_IDLE && start && ready_again) begin
         ph = PH_PULSE;
         pulse_n = '0;
      end
      span = (PULSE_BITS+1)'(settle_len) + (PULSE_BITS+1)'(high_len);
      case (ph)
         PH_PULSE: begin
            if (pulse_n >= settle_len && pulse_n < span) r.trig = 1'b1;
            if (pulse_n < span) pulse_n = pulse_n + 1'b1;
            if (pulse_n >= span) ph = PH_AWAIT;
         end
         PH_AWAIT: begin
            if (echo) begin
               ph = PH_MEAS;
               echo_n = ECHO_BITS'(1);
            end
         end
         PH_MEAS: begin
            if (echo) begin
               if (echo_n != '1) echo_n = echo_n + 1'b1;
            end else begin
               // 0.017 cm per tick in q0.16, truncated
               product = (ECHO_BITS+DIST_SCALE_BITS)'(echo_n)
                         * (ECHO_BITS+DIST_SCALE_BITS)'(DIST_SCALE);
               if ((product >> DIST_FRAC_BITS) > DIST_MAX) dist_q = DIST_MAX;
               else dist_q = DIST_BITS'(product >> DIST_FRAC_BITS);
               r.done = 1'b1;
               ph = PH_IDLE;
               since_n = '0;
            end
         end
         default: ;
      endcase
      if (ph == PH_MEAS) r.status = STATUS_MEAS;
      else if (ph == PH_IDLE) r.status = STATUS_IDLE;
      else r.status = STATUS_BUSY;
      r.range_cm = dist_q;
   endtask

   always @(posedge clock) begin : watch
      reading_type want;
      reading_type got;
      if (reset) begin
         min_gap = MIN_INTERVAL_RST;
         high_len = TRIG_HIGH_RST;
         settle_len = SETTLE_LOW_RST;
         ph = PH_IDLE;
         pulse_n = '0;
         echo_n = '0;
         since_n = '1;
         dist_q = '0;
         pending_readings.delete();
         mismatches = 0;
         distances_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.trig = rsp_tdata[0];
            got.status = rsp_tdata[2:1];
            got.range_cm = rsp_tdata[13:3];
            got.done = rsp_tdata[14];
            if (pending_readings.size() == 0) begin
               $error("rsp word %h with nothing outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               if (got.trig !== want.trig) begin
                  $error("trigger_level: expected %0d, got %0d", want.trig, got.trig);
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $error("phase_status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.range_cm !== want.range_cm) begin
                  $error("distance_cm: expected %0d, got %0d", want.range_cm, got.range_cm);
                  mismatches++;
               end
               if (got.done !== want.done) begin
                  $error("measure_done: expected %0d, got %0d", want.done, got.done);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_ranger(req_tdata[0], req_tdata[1], want);
            if (want.done) distances_seen++;
            pending_readings.push_back(want);
         end
         // writes only land while the stream is quiet
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_INTERVAL: min_gap = csr_wdata[INTERVAL_BITS-1:0];
               CSR_TRIG_HIGH:    high_len = csr_wdata[TRIG_BITS-1:0];
               CSR_SETTLE_LOW:   settle_len = csr_wdata[TRIG_BITS-1:0];
               default: ;
            endcase
         end
      end
      backlog <= pending_readings.size();
   end

endmodule

// File: tb/tb_ultrasonic_echo_ranger.sv
// testbench top for the ultrasonic echo ranger: drives tick words and csr writes,
// stalls both sides at random and gives the verdict; depends on uer_pkg,
// ultrasonic_echo_ranger and ranger_checker
module tb_ultrasonic_echo_ranger;
   import uer_pkg::*;

   // slowest run: ~2k ticks with gaps and stalls in between
   localparam int LIMIT_CYCLES    = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatches;
   int distances_seen;
   int backlog;
   int ticks_sent = 0;
   int cycle_count = 0;
   bit pace_on = 1'b0;
   bit hold_off_req = 1'b0;

   logic [INTERVAL_BITS-1:0] cfg_min;
   logic [TRIG_BITS-1:0]     cfg_high;
   logic [TRIG_BITS-1:0]     cfg_settle;

   ultrasonic_echo_ranger dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ranger_checker ranger_chk (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .distances_seen(distances_seen),
      .backlog(backlog)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count, backlog);
         $display("ultrasonic_echo_ranger: mismatch");
         $finish;
      end
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int echo_span();
      int r;
      r = $urandom_range(0, 19);
      if (r < 16) return $urandom_range(1, 40);
      if (r < 19) return $urandom_range(41, 150);
      return $urandom_range(151, 400);
   endfunction

   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (pace_on && $urandom_range(0, 9) < 2) stall = pause_len();
         end
      end
   end

   task automatic send_word(input logic echo, input logic start);
      int gap;
      gap = 0;
      if (pace_on && $urandom_range(0, 9) < 3) gap = pause_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_BITS-2){1'b0}}, start, echo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // drop valid and let every outstanding word drain
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_ranger(input int min_ticks, input int high_ticks,
                                 input int settle_ticks);
      cfg_min = INTERVAL_BITS'(min_ticks);
      cfg_high = TRIG_BITS'(high_ticks);
      cfg_settle = TRIG_BITS'(settle_ticks);
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_INTERVAL;
      csr_wdata <= cfg_min;
      @(posedge clock);
      csr_index <= CSR_TRIG_HIGH;
      csr_wdata <= CSR_DATA_BITS'(cfg_high);
      @(posedge clock);
      csr_index <= CSR_SETTLE_LOW;
      csr_wdata <= CSR_DATA_BITS'(cfg_settle);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // idle lead-in, start, pulse with echo noise, wait, echo high run, fall
   task automatic measure_once(input int echo_len);
      int lead;
      int span;
      span = cfg_settle + cfg_high;
      if ($urandom_range(0, 4) != 0) lead = cfg_min + $urandom_range(0, 3);
      else lead = $urandom_range(0, cfg_min + 1);
      repeat (lead) send_word(1'($urandom_range(0, 1)), 1'b0);
      send_word(1'($urandom_range(0, 1)), 1'b1);
      repeat (span > 0 ? span - 1 : 0)
         send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 5)) send_word(1'b0, 1'($urandom_range(0, 1)));
      repeat (echo_len) send_word(1'b1, $urandom_range(0, 7) == 0);
      send_word(1'b0, $urandom_range(0, 7) == 0);
   endtask

   task automatic measure_or_noise();
      pace_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12))
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         measure_once(echo_span());
      end
   endtask

   task automatic random_phase(input int min_ticks, input int high_ticks,
                               input int settle_ticks, input int n, input bit squeeze);
      int goal;
      drain();
      program_ranger(min_ticks, high_ticks, settle_ticks);
      goal = ticks_sent + n;
      if (squeeze) hold_off_req = 1'b1;
      while (ticks_sent < goal) measure_or_noise();
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      pace_on = 1'b1;

      // longest interval, no settle, no high time: pulse folds into the start tick
      program_ranger(20'hFFFFF, 0, 0);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b0);
      // too soon for the longest interval
      send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b0);
      drain();

      // zero interval: restart straight after the fall
      program_ranger(0, 1, 2);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b1);
      send_word(1'b0, 1'b1);
      send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      drain();

      random_phase(0, 1, 0, 150, 1'b0);
      random_phase($urandom_range(1, 40), $urandom_range(1, 12), $urandom_range(0, 12),
                   150, 1'b0);

      // widest trigger pulse
      drain();
      program_ranger($urandom_range(0, 20), 255, 255);
      pace_on = 1'b1;
      measure_once($urandom_range(1, 40));

      random_phase($urandom_range(0, 30), $urandom_range(1, 20), $urandom_range(0, 20),
                   150, 1'b1);

      drain();
      repeat (4) @(posedge clock);
      $display("%0d tick words over %0d cycles, %0d distances completed", ticks_sent,
               cycle_count, distances_seen);
      $display("settle and high widths 0 to 255, interval 0 to max, stalls on both sides");
      if (mismatches == 0) begin
         $display("ultrasonic_echo_ranger: match");
      end else begin
         $display("ultrasonic_echo_ranger: mismatch");
      end
      $finish;
   end

endmodule
